>>> design/stq_pkg.sv
// Shared types and constants of the sorted timer expiry queue.
package stq_pkg;

  localparam int unsigned IdW = 4;
  localparam int unsigned TimeW = 63;
  localparam int unsigned MaskW = 16;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  localparam logic [ApbAddrW-3:0] RegRealtimeMask = '0;

  typedef enum logic [1:0] {
    REQ_ARM    = 2'd0,
    REQ_DISARM = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_RUN    = 2'd3
  } req_e;

  typedef struct packed {
    logic             fired_valid;
    logic [IdW-1:0]   fired_timer;
    logic             is_pending;
    logic [TimeW-1:0] stored_expiry;
    logic             last;
  } result_t;

endpackage

>>> design/sorted_timer_expiry_queue_unit.sv
// Top level of the sorted timer expiry queue: request sequencer, slot state and result register.
//
// Each request is taken only while the unit is idle and is worked through by one sequencer
// that reads the order memory and the expiry memory one entry at a time. One comparator
// checks the expiry read back against the arm expiry or the run time. A query reads the
// expiry memory, a disarm removes the slot from its queue, and an arm first removes a pending
// slot from its queue and then does the sorted insert that walks from the tail. A run examines
// entries from the head and moves each entry behind the fired ones up. While out_stall_i holds
// the result register, a state that must emit a result waits. The rate is set by the single
// read port of each memory and by the chain order-memory read, expiry-memory read, compare for
// every entry visited. There is no clearing pass after reset.
module sorted_timer_expiry_queue_unit #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [stq_pkg::ApbAddrW-1:0]     paddr,
  input  logic [stq_pkg::ApbDataW-1:0]     pwdata,
  output logic [stq_pkg::ApbDataW-1:0]     prdata,
  output logic                             pready,

  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       req_type_i,
  input  logic [stq_pkg::IdW-1:0]          timer_id_i,
  input  logic [stq_pkg::TimeW-1:0]        expire_time_i,
  input  logic                             clock_sel_i,
  input  logic [stq_pkg::TimeW-1:0]        now_time_i,

  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             fired_valid_o,
  output logic [stq_pkg::IdW-1:0]          fired_timer_o,
  output logic                             is_pending_o,
  output logic [stq_pkg::TimeW-1:0]        stored_expiry_o,
  output logic                             last_o
);

  localparam int unsigned SW = $clog2(NUM_TIMERS);
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);
  localparam int unsigned QAW = SW + 1;
  localparam int unsigned QDEPTH = 2 ** QAW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RM_CHK,
    S_RM_STEP,
    S_IN_INIT,
    S_IN_CHK,
    S_IN_RDE,
    S_IN_CMP,
    S_RUN_CHK,
    S_RUN_RDE,
    S_RUN_CMP,
    S_FIN,
    S_QRES,
    S_ACK
  } state_e;

  state_e                          state_q, state_d;
  stq_pkg::req_e                   req_q, req_d;
  logic [stq_pkg::IdW-1:0]         id_q, id_d;
  logic [SW-1:0]                   sid_q, sid_d;
  logic                            ok_q, ok_d;
  logic [stq_pkg::TimeW-1:0]       exp_q, exp_d;
  logic [stq_pkg::TimeW-1:0]       now_q, now_d;
  logic                            qsel_q, qsel_d;
  logic [CW-1:0]                   idx_q, idx_d;
  logic [CW-1:0]                   kcnt_q, kcnt_d;
  logic                            found_q, found_d;
  logic                            firing_q, firing_d;
  logic [stq_pkg::IdW-1:0]         entry_q, entry_d;
  logic                            held_v_q, held_v_d;
  logic [stq_pkg::IdW-1:0]         held_id_q, held_id_d;
  logic [stq_pkg::TimeW-1:0]       held_exp_q, held_exp_d;
  logic [1:0][CW-1:0]              cnt_q, cnt_d;
  logic [NUM_TIMERS-1:0]           pend_q, pend_d;
  logic [NUM_TIMERS-1:0]           side_q, side_d;
  logic [NUM_TIMERS-1:0]           wr_q, wr_d;
  logic [stq_pkg::MaskW-1:0]       mask_q, mask_d;
  stq_pkg::result_t                out_q, out_d;
  logic                            out_valid_q, out_valid_d;

  logic                            qram_we;
  logic [QAW-1:0]                  qram_waddr;
  logic [stq_pkg::IdW-1:0]         qram_wdata;
  logic [QAW-1:0]                  qram_raddr;
  logic [stq_pkg::IdW-1:0]         qram_rdata;
  logic                            eram_we;
  logic [SW-1:0]                   eram_waddr;
  logic [stq_pkg::TimeW-1:0]       eram_wdata;
  logic [SW-1:0]                   eram_raddr;
  logic [stq_pkg::TimeW-1:0]       eram_rdata;

  logic                            out_free;
  logic                            emit;
  stq_pkg::result_t                emit_res;
  logic                            ok_in;
  logic [SW-1:0]                   sid_in;
  logic [CW-1:0]                   idx_m1;
  logic [CW-1:0]                   idx_mk;
  logic                            cfg_wr;
  logic [stq_pkg::TimeW-1:0]       cmp_limit;
  logic                            cmp_later;

  stq_ram #(
    .WIDTH(stq_pkg::IdW),
    .DEPTH(QDEPTH)
  ) u_order_ram (
    .clk_i  (clk_i),
    .we_i   (qram_we),
    .waddr_i(qram_waddr),
    .wdata_i(qram_wdata),
    .raddr_i(qram_raddr),
    .rdata_o(qram_rdata)
  );

  stq_ram #(
    .WIDTH(stq_pkg::TimeW),
    .DEPTH(NUM_TIMERS)
  ) u_expiry_ram (
    .clk_i  (clk_i),
    .we_i   (eram_we),
    .waddr_i(eram_waddr),
    .wdata_i(eram_wdata),
    .raddr_i(eram_raddr),
    .rdata_o(eram_rdata)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[stq_pkg::ApbAddrW-1:2] == stq_pkg::RegRealtimeMask);
  assign prdata = (paddr[stq_pkg::ApbAddrW-1:2] == stq_pkg::RegRealtimeMask) ?
                  stq_pkg::ApbDataW'(mask_q) : '0;

  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign ok_in = (32'(timer_id_i) < 32'(NUM_TIMERS));
  assign sid_in = SW'(timer_id_i);
  assign idx_m1 = idx_q - CW'(1);
  assign idx_mk = idx_q - kcnt_q;
  assign cmp_limit = (req_q == stq_pkg::REQ_RUN) ? now_q : exp_q;
  assign cmp_later = (eram_rdata > cmp_limit);

  always_comb begin
    state_d = state_q;
    req_d = req_q;
    id_d = id_q;
    sid_d = sid_q;
    ok_d = ok_q;
    exp_d = exp_q;
    now_d = now_q;
    qsel_d = qsel_q;
    idx_d = idx_q;
    kcnt_d = kcnt_q;
    found_d = found_q;
    firing_d = firing_q;
    entry_d = entry_q;
    held_v_d = held_v_q;
    held_id_d = held_id_q;
    held_exp_d = held_exp_q;
    cnt_d = cnt_q;
    pend_d = pend_q;
    side_d = side_q;
    wr_d = wr_q;
    mask_d = mask_q;
    out_d = out_q;
    out_valid_d = out_valid_q;

    qram_we = 1'b0;
    qram_waddr = '0;
    qram_wdata = '0;
    qram_raddr = '0;
    eram_we = 1'b0;
    eram_waddr = '0;
    eram_wdata = '0;
    eram_raddr = SW'(entry_q);

    emit = 1'b0;
    emit_res = '0;

    if (cfg_wr) begin
      mask_d = pwdata[stq_pkg::MaskW-1:0];
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = stq_pkg::req_e'(req_type_i);
          id_d = timer_id_i;
          sid_d = sid_in;
          ok_d = ok_in;
          exp_d = expire_time_i;
          now_d = now_time_i;
          idx_d = '0;
          kcnt_d = '0;
          found_d = 1'b0;
          firing_d = 1'b1;
          held_v_d = 1'b0;
          case (stq_pkg::req_e'(req_type_i))
            stq_pkg::REQ_ARM: begin
              if (ok_in) begin
                eram_we = 1'b1;
                eram_waddr = sid_in;
                eram_wdata = expire_time_i;
                wr_d[sid_in] = 1'b1;
                if (pend_q[sid_in]) begin
                  qsel_d = side_q[sid_in];
                  state_d = S_RM_CHK;
                end else begin
                  state_d = S_IN_INIT;
                end
              end else begin
                state_d = S_ACK;
              end
            end
            stq_pkg::REQ_DISARM: begin
              if (ok_in && pend_q[sid_in]) begin
                qsel_d = side_q[sid_in];
                state_d = S_RM_CHK;
              end else begin
                state_d = S_ACK;
              end
            end
            stq_pkg::REQ_QUERY: begin
              eram_raddr = sid_in;
              state_d = S_QRES;
            end
            stq_pkg::REQ_RUN: begin
              qsel_d = clock_sel_i;
              state_d = S_RUN_CHK;
            end
            default: begin
              state_d = S_ACK;
            end
          endcase
        end
      end

      S_RM_CHK: begin
        if (idx_q == cnt_q[qsel_q]) begin
          cnt_d[qsel_q] = cnt_q[qsel_q] - CW'(1);
          pend_d[sid_q] = 1'b0;
          state_d = (req_q == stq_pkg::REQ_ARM) ? S_IN_INIT : S_ACK;
        end else begin
          qram_raddr = {qsel_q, idx_q[SW-1:0]};
          state_d = S_RM_STEP;
        end
      end

      S_RM_STEP: begin
        if (found_q) begin
          qram_we = 1'b1;
          qram_waddr = {qsel_q, idx_m1[SW-1:0]};
          qram_wdata = qram_rdata;
        end else if (qram_rdata == id_q) begin
          found_d = 1'b1;
        end
        idx_d = idx_q + CW'(1);
        state_d = S_RM_CHK;
      end

      S_IN_INIT: begin
        qsel_d = mask_q[id_q];
        idx_d = cnt_q[mask_q[id_q]];
        state_d = S_IN_CHK;
      end

      S_IN_CHK: begin
        if (idx_q == '0) begin
          qram_we = 1'b1;
          qram_waddr = {qsel_q, {SW{1'b0}}};
          qram_wdata = id_q;
          cnt_d[qsel_q] = cnt_q[qsel_q] + CW'(1);
          pend_d[sid_q] = 1'b1;
          side_d[sid_q] = qsel_q;
          state_d = S_ACK;
        end else begin
          qram_raddr = {qsel_q, idx_m1[SW-1:0]};
          state_d = S_IN_RDE;
        end
      end

      S_IN_RDE: begin
        entry_d = qram_rdata;
        eram_raddr = SW'(qram_rdata);
        state_d = S_IN_CMP;
      end

      S_IN_CMP: begin
        qram_we = 1'b1;
        qram_waddr = {qsel_q, idx_q[SW-1:0]};
        if (cmp_later) begin
          qram_wdata = entry_q;
          idx_d = idx_m1;
          state_d = S_IN_CHK;
        end else begin
          qram_wdata = id_q;
          cnt_d[qsel_q] = cnt_q[qsel_q] + CW'(1);
          pend_d[sid_q] = 1'b1;
          side_d[sid_q] = qsel_q;
          state_d = S_ACK;
        end
      end

      S_RUN_CHK: begin
        if (idx_q == cnt_q[qsel_q]) begin
          state_d = S_FIN;
        end else begin
          qram_raddr = {qsel_q, idx_q[SW-1:0]};
          state_d = S_RUN_RDE;
        end
      end

      S_RUN_RDE: begin
        entry_d = qram_rdata;
        eram_raddr = SW'(qram_rdata);
        if (firing_q) begin
          state_d = S_RUN_CMP;
        end else begin
          qram_we = 1'b1;
          qram_waddr = {qsel_q, idx_mk[SW-1:0]};
          qram_wdata = qram_rdata;
          idx_d = idx_q + CW'(1);
          state_d = S_RUN_CHK;
        end
      end

      S_RUN_CMP: begin
        if (!cmp_later) begin
          if (!held_v_q || out_free) begin
            if (held_v_q) begin
              emit = 1'b1;
              emit_res.fired_valid = 1'b1;
              emit_res.fired_timer = held_id_q;
              emit_res.stored_expiry = held_exp_q;
            end
            held_v_d = 1'b1;
            held_id_d = entry_q;
            held_exp_d = eram_rdata;
            pend_d[SW'(entry_q)] = 1'b0;
            kcnt_d = kcnt_q + CW'(1);
            idx_d = idx_q + CW'(1);
            state_d = S_RUN_CHK;
          end
        end else begin
          firing_d = 1'b0;
          qram_we = 1'b1;
          qram_waddr = {qsel_q, idx_mk[SW-1:0]};
          qram_wdata = entry_q;
          idx_d = idx_q + CW'(1);
          state_d = S_RUN_CHK;
        end
      end

      S_FIN: begin
        if (out_free) begin
          emit = 1'b1;
          emit_res.fired_valid = held_v_q;
          emit_res.fired_timer = held_v_q ? held_id_q : '0;
          emit_res.stored_expiry = held_v_q ? held_exp_q : '0;
          emit_res.last = 1'b1;
          cnt_d[qsel_q] = cnt_q[qsel_q] - kcnt_q;
          state_d = S_IDLE;
        end
      end

      S_QRES: begin
        eram_raddr = sid_q;
        if (out_free) begin
          emit = 1'b1;
          emit_res.last = 1'b1;
          if (ok_q) begin
            emit_res.is_pending = pend_q[sid_q];
            emit_res.stored_expiry = wr_q[sid_q] ? eram_rdata : '0;
          end
          state_d = S_IDLE;
        end
      end

      S_ACK: begin
        if (out_free) begin
          emit = 1'b1;
          emit_res.last = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_d = emit_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q <= stq_pkg::REQ_ARM;
      id_q <= '0;
      sid_q <= '0;
      ok_q <= 1'b0;
      exp_q <= '0;
      now_q <= '0;
      qsel_q <= 1'b0;
      idx_q <= '0;
      kcnt_q <= '0;
      found_q <= 1'b0;
      firing_q <= 1'b0;
      entry_q <= '0;
      held_v_q <= 1'b0;
      held_id_q <= '0;
      held_exp_q <= '0;
      cnt_q <= '0;
      pend_q <= '0;
      side_q <= '0;
      wr_q <= '0;
      mask_q <= '0;
      out_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      req_q <= req_d;
      id_q <= id_d;
      sid_q <= sid_d;
      ok_q <= ok_d;
      exp_q <= exp_d;
      now_q <= now_d;
      qsel_q <= qsel_d;
      idx_q <= idx_d;
      kcnt_q <= kcnt_d;
      found_q <= found_d;
      firing_q <= firing_d;
      entry_q <= entry_d;
      held_v_q <= held_v_d;
      held_id_q <= held_id_d;
      held_exp_q <= held_exp_d;
      cnt_q <= cnt_d;
      pend_q <= pend_d;
      side_q <= side_d;
      wr_q <= wr_d;
      mask_q <= mask_d;
      out_q <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign fired_valid_o = out_q.fired_valid;
  assign fired_timer_o = out_q.fired_timer;
  assign is_pending_o = out_q.is_pending;
  assign stored_expiry_o = out_q.stored_expiry;
  assign last_o = out_q.last;

`ifndef ASSERT_OFF
  a_count_matches_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (int'(cnt_q[0]) + int'(cnt_q[1]) == $countones(pend_q)))
    else $error("queue occupancy disagrees with the pending flags");

  a_early_result_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last) |-> out_q.fired_valid)
    else $error("a result that is not the last one of its request reports no fired timer");

  a_pending_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pend_q & ~wr_q) == '0))
    else $error("a pending slot has never had its expiry written");

  a_run_drains_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !held_v_q || !in_valid_i || $past(state_q == S_FIN)
      || $past(state_q == S_IDLE) || $past(state_q == S_ACK) || $past(state_q == S_QRES))
    else $error("the idle state was reached without passing through a result state");
`endif

endmodule

>>> design/stq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module stq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the sorted timer expiry queue unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [stq_pkg::TimeW-1:0] MaxTime = '1;
  localparam logic [stq_pkg::ApbAddrW-1:0] MaskAddr = {stq_pkg::RegRealtimeMask, 2'b00};
  localparam int unsigned HoldCycles = 400;

  class expiry_schedule;
    typedef logic [stq_pkg::IdW-1:0] slot_list_t[$];

    logic [stq_pkg::TimeW-1:0] expiry [16];
    bit                        armed [16];
    slot_list_t                order [2];
    logic [stq_pkg::MaskW-1:0] mask;
    stq_pkg::result_t          due_results[$];
    int unsigned               mismatches;

    function new();
      foreach (expiry[i]) begin
        expiry[i] = '0;
        armed[i] = 1'b0;
      end
      mask = '0;
      mismatches = 0;
    endfunction

    task flag_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    function void set_mask(logic [stq_pkg::MaskW-1:0] value);
      mask = value;
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction

    function void pull(logic [stq_pkg::IdW-1:0] id);
      for (int q = 0; q < 2; q++) begin
        for (int i = 0; i < order[q].size(); i++) begin
          if (order[q][i] == id) begin
            order[q].delete(i);
            armed[id] = 1'b0;
            return;
          end
        end
      end
      armed[id] = 1'b0;
    endfunction

    function void put(logic [stq_pkg::IdW-1:0] id, logic [stq_pkg::TimeW-1:0] when);
      int unsigned q;
      int unsigned pos;
      q = mask[id];
      pos = 0;
      if (order[q].size() >= 16) return;
      while (pos < order[q].size() && expiry[order[q][pos]] <= when) pos++;
      order[q].insert(pos, id);
      expiry[id] = when;
      armed[id] = 1'b1;
    endfunction

    function void take_request(stq_pkg::req_e kind, logic [stq_pkg::IdW-1:0] id,
                               logic [stq_pkg::TimeW-1:0] when,
                               logic clk_sel, logic [stq_pkg::TimeW-1:0] now);
      stq_pkg::result_t plain;
      stq_pkg::result_t prev;
      stq_pkg::result_t fire;
      logic [stq_pkg::IdW-1:0] head;
      int unsigned fired;
      plain = '0;
      plain.last = 1'b1;
      prev = '0;
      fired = 0;
      case (kind)
        stq_pkg::REQ_ARM: begin
          if (armed[id]) pull(id);
          put(id, when);
          due_results.push_back(plain);
        end
        stq_pkg::REQ_DISARM: begin
          if (armed[id]) pull(id);
          due_results.push_back(plain);
        end
        stq_pkg::REQ_QUERY: begin
          plain.is_pending = armed[id];
          plain.stored_expiry = expiry[id];
          due_results.push_back(plain);
        end
        default: begin
          while (order[clk_sel].size() > 0 && fired < 16) begin
            head = order[clk_sel][0];
            if (expiry[head] > now) break;
            void'(order[clk_sel].pop_front());
            armed[head] = 1'b0;
            fire = '0;
            fire.fired_valid = 1'b1;
            fire.fired_timer = head;
            fire.stored_expiry = expiry[head];
            if (fired > 0) due_results.push_back(prev);
            prev = fire;
            fired++;
          end
          if (fired == 0) begin
            due_results.push_back(plain);
          end else begin
            prev.last = 1'b1;
            due_results.push_back(prev);
          end
        end
      endcase
    endfunction

    task match_result(stq_pkg::result_t seen);
      stq_pkg::result_t want;
      if (due_results.size() == 0) begin
        flag_mismatch("result arrived with no request waiting");
        return;
      end
      want = due_results.pop_front();
      if (seen.fired_valid !== want.fired_valid)
        flag_mismatch($sformatf("fired_valid got %b wanted %b",
                                seen.fired_valid, want.fired_valid));
      if (seen.fired_timer !== want.fired_timer)
        flag_mismatch($sformatf("fired_timer got %0d wanted %0d",
                                seen.fired_timer, want.fired_timer));
      if (seen.is_pending !== want.is_pending)
        flag_mismatch($sformatf("is_pending got %b wanted %b",
                                seen.is_pending, want.is_pending));
      if (seen.stored_expiry !== want.stored_expiry)
        flag_mismatch($sformatf("stored_expiry got %h wanted %h",
                                seen.stored_expiry, want.stored_expiry));
      if (seen.last !== want.last)
        flag_mismatch($sformatf("last got %b wanted %b", seen.last, want.last));
    endtask
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [stq_pkg::ApbAddrW-1:0] paddr;
  logic [stq_pkg::ApbDataW-1:0] pwdata;
  logic [stq_pkg::ApbDataW-1:0] prdata;
  logic                         pready;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [1:0]                   req_type_i;
  logic [stq_pkg::IdW-1:0]      timer_id_i;
  logic [stq_pkg::TimeW-1:0]    expire_time_i;
  logic                         clock_sel_i;
  logic [stq_pkg::TimeW-1:0]    now_time_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic                         fired_valid_o;
  logic [stq_pkg::IdW-1:0]      fired_timer_o;
  logic                         is_pending_o;
  logic [stq_pkg::TimeW-1:0]    stored_expiry_o;
  logic                         last_o;
  stq_pkg::result_t             seen_result;

  expiry_schedule sched = new();
  bit          calm;
  int unsigned hold_requests;
  int unsigned requests_sent;

  assign seen_result = {fired_valid_o, fired_timer_o, is_pending_o, stored_expiry_o, last_o};

  sorted_timer_expiry_queue_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .timer_id_i     (timer_id_i),
    .expire_time_i  (expire_time_i),
    .clock_sel_i    (clock_sel_i),
    .now_time_i     (now_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fired_valid_o  (fired_valid_o),
    .fired_timer_o  (fired_timer_o),
    .is_pending_o   (is_pending_o),
    .stored_expiry_o(stored_expiry_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : receiver
    int unsigned served;
    served = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != served) begin
        served++;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 16);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      sched.match_result(seen_result);
  end

  function automatic logic [stq_pkg::TimeW-1:0] pick_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return stq_pkg::TimeW'($urandom_range(0, 40));
      5, 6, 7: return stq_pkg::TimeW'(w[23:0]);
      8: return w[stq_pkg::TimeW-1:0];
      default: return MaxTime - stq_pkg::TimeW'($urandom_range(0, 2));
    endcase
  endfunction

  task automatic send_request(input stq_pkg::req_e kind, input logic [stq_pkg::IdW-1:0] id,
                              input logic [stq_pkg::TimeW-1:0] when, input logic clk_sel,
                              input logic [stq_pkg::TimeW-1:0] now);
    if (!calm && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    timer_id_i <= id;
    expire_time_i <= when;
    clock_sel_i <= clk_sel;
    now_time_i <= now;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sched.take_request(kind, id, when, clk_sel, now);
    requests_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sched.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_mask(input logic [stq_pkg::MaskW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MaskAddr;
    pwdata <= stq_pkg::ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    sched.set_mask(value);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    if (prdata !== stq_pkg::ApbDataW'(value))
      sched.flag_mismatch($sformatf("mask read back %h, written %h", prdata, value));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic arm_all_then_run();
    for (int s = 0; s < 16; s++)
      send_request(stq_pkg::REQ_ARM, stq_pkg::IdW'(s), pick_time(), 1'b0, '0);
    send_request(stq_pkg::REQ_RUN, '0, '0, 1'b0, MaxTime);
    send_request(stq_pkg::REQ_RUN, '0, '0, 1'b1, MaxTime);
  endtask

  task automatic random_step();
    int unsigned pick;
    stq_pkg::req_e kind;
    logic [stq_pkg::TimeW-1:0] now;
    pick = $urandom_range(0, 99);
    if (pick < 40) kind = stq_pkg::REQ_ARM;
    else if (pick < 55) kind = stq_pkg::REQ_DISARM;
    else if (pick < 70) kind = stq_pkg::REQ_QUERY;
    else kind = stq_pkg::REQ_RUN;
    now = ($urandom_range(0, 3) == 0) ? MaxTime : pick_time();
    send_request(kind, stq_pkg::IdW'($urandom_range(0, 15)), pick_time(),
                 1'($urandom_range(0, 1)), now);
  endtask

  task automatic random_phase(input int unsigned count, input bit with_fill);
    int unsigned target;
    target = requests_sent + count;
    if (with_fill) arm_all_then_run();
    while (requests_sent < target) begin
      if ($urandom_range(0, 39) == 0) arm_all_then_run();
      else random_step();
    end
  endtask

  initial begin
    calm = 1'b0;
    hold_requests = 0;
    requests_sent = 0;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    req_type_i <= stq_pkg::REQ_ARM;
    timer_id_i <= '0;
    expire_time_i <= '0;
    clock_sel_i <= 1'b0;
    now_time_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_mask(16'h00F0);
    send_request(stq_pkg::REQ_QUERY, 4'd0, '0, 1'b0, '0);
    send_request(stq_pkg::REQ_RUN, 4'd0, '0, 1'b0, '0);
    send_request(stq_pkg::REQ_ARM, 4'd0, MaxTime, 1'b0, '0);
    send_request(stq_pkg::REQ_ARM, 4'd1, '0, 1'b0, '0);
    send_request(stq_pkg::REQ_ARM, 4'd2, 63'd5, 1'b0, '0);
    send_request(stq_pkg::REQ_ARM, 4'd3, 63'd5, 1'b0, '0);
    send_request(stq_pkg::REQ_ARM, 4'd4, 63'd100, 1'b0, '0);
    send_request(stq_pkg::REQ_QUERY, 4'd0, '0, 1'b0, '0);
    send_request(stq_pkg::REQ_ARM, 4'd2, 63'd5, 1'b0, '0);
    send_request(stq_pkg::REQ_DISARM, 4'd1, '0, 1'b0, '0);
    send_request(stq_pkg::REQ_DISARM, 4'd1, '0, 1'b0, '0);
    send_request(stq_pkg::REQ_RUN, 4'd0, '0, 1'b1, 63'd99);
    send_request(stq_pkg::REQ_RUN, 4'd0, '0, 1'b0, 63'd5);
    send_request(stq_pkg::REQ_QUERY, 4'd2, '0, 1'b0, '0);
    send_request(stq_pkg::REQ_RUN, 4'd0, '0, 1'b1, MaxTime);
    send_request(stq_pkg::REQ_RUN, 4'd0, '0, 1'b0, MaxTime);
    send_request(stq_pkg::REQ_ARM, 4'd5, 63'd7, 1'b0, '0);
    send_request(stq_pkg::REQ_ARM, 4'd6, 63'd9, 1'b0, '0);
    send_request(stq_pkg::REQ_ARM, 4'd7, 63'd11, 1'b0, '0);
    send_request(stq_pkg::REQ_ARM, 4'd15, pick_time(), 1'b0, '0);
    settle();

    // The slots armed above stay in the queue they went into under the old mask until armed again.
    write_mask(16'h0F0F);
    send_request(stq_pkg::REQ_ARM, 4'd5, 63'd3, 1'b0, '0);
    send_request(stq_pkg::REQ_DISARM, 4'd6, '0, 1'b0, '0);
    send_request(stq_pkg::REQ_QUERY, 4'd6, '0, 1'b0, '0);
    send_request(stq_pkg::REQ_RUN, 4'd0, '0, 1'b1, MaxTime);
    send_request(stq_pkg::REQ_RUN, 4'd0, '0, 1'b0, MaxTime);
    settle();

    write_mask(16'h0000);
    random_phase(40, 1'b1);
    hold_requests++;
    random_phase(50, 1'b0);
    settle();

    write_mask(16'hFFFF);
    calm = 1'b1;
    random_phase(45, 1'b1);
    settle();
    random_phase(45, 1'b0);
    settle();
    calm = 1'b0;

    write_mask(16'($urandom));
    random_phase(90, 1'b0);
    settle();

    write_mask(16'($urandom));
    random_phase(75, 1'b0);
    settle();
    repeat (20) @(posedge clk_i);

    if (sched.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
design/stq_pkg.sv
design/stq_ram.sv
design/sorted_timer_expiry_queue_unit.sv
bench/tb_top.sv
